// File: hw/rtl/frame_time_integral_gap_fill_unit_assert.svh
// Assertion macros shared by the gap-fill integrator.
`ifndef FRAME_TIME_INTEGRAL_GAP_FILL_UNIT_ASSERT_SVH
`define FRAME_TIME_INTEGRAL_GAP_FILL_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FTIG_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FTIG_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ftig_pkg.sv
package ftig_pkg;

    // Field widths of the two channels.
    localparam int VALUE_W   = 32;
    localparam int TIME_W    = 32;
    localparam int ACC_W     = 64;
    localparam int S_TDATA_W = VALUE_W + 3 * TIME_W;

    // Time fraction bits; a frame without times lasts one second.
    localparam int TIME_FRAC_BITS = 8;

    // Shared multiplier: 34 x 34 signed covers all three products.
    localparam int MUL_W  = 34;
    localparam int PROD_W = 2 * MUL_W;

    // Interpolation divider: dividend up to 65 bits, divisor 33 bits,
    // quotient clamped at 2^QCLAMP_BITS.
    localparam int DIVD_W      = 65;
    localparam int DEN_W       = 33;
    localparam int QCLAMP_BITS = 40;
    localparam int QUOT_W      = QCLAMP_BITS + 1;
    localparam int DIV_STEPS   = QCLAMP_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [MUL_W-1:0] UNIT_DURATION = MUL_W'(1) << TIME_FRAC_BITS;

    // Register byte addresses.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] ADDR_TIMES_PRESENT = 3'd0;

    // Operand selection for the shared multiplier.
    typedef enum logic [1:0] {
        MUL_DUR    = 2'd0,
        MUL_INTERP = 2'd1,
        MUL_GAP    = 2'd2
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     capture;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     add_frame;
        logic     div_init;
        logic     div_step;
        logic     interp_en;
        logic     add_gap;
        logic     finish;
        logic     emit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic gap_needed;
        logic big;
        logic is_last;
        logic out_busy;
    } ctrl_status_t;

endpackage

// File: hw/rtl/frame_time_integral_gap_fill_unit.sv
// Channel   | Direction | tdata (low bit up)                        | tuser / tlast
// ----------+-----------+-------------------------------------------+------------------------
// s_ frames | in        | sample_value, frame_start, frame_end, mid | tuser is_first, tlast is_last
// m_ result | out       | integral                                  | tuser error_flag, saturated
// APB cfg   | in        | register 0 at byte 0: times_present       | -
//
// A frame without a gap passes the duration product and the accumulate before it finishes.
// A frame with a gap also runs the interpolation divider, one quotient bit per cycle
// over 40 steps; when the quotient clamps, the divider steps are skipped.
// Reset is synchronous and active low; all run state reads as zero after it.
// A last frame waits before loading the output register while an earlier result
// is still held there; a new request is taken while a result waits.
`include "frame_time_integral_gap_fill_unit_assert.svh"

module frame_time_integral_gap_fill_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // sample_value [31:0], frame_start [63:32], frame_end [95:64], frame_mid [127:96]
    input  logic [ftig_pkg::S_TDATA_W-1:0]     s_tdata,
    // is_first [0]
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // integral [63:0]
    output logic [ftig_pkg::ACC_W-1:0]         m_tdata,
    // error_flag [0], saturated [1]
    output logic [1:0]                         m_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ftig_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);
    import ftig_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         times_present_reg;
    logic         reg_hit;

    // Configuration register; byte addresses 0 to 3 all select it, 4 to 7 are ignored.
    assign pready  = 1'b1;
    assign reg_hit = paddr[PADDR_W-1] == ADDR_TIMES_PRESENT[PADDR_W-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            times_present_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_hit) begin
            times_present_reg <= pwdata[0];
        end
    end

    assign prdata = reg_hit ? {31'd0, times_present_reg} : 32'd0;

    ftig_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ftig_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .times_present (times_present_reg),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .s_tlast       (s_tlast),
        .cmd           (cmd),
        .status        (status),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser)
    );

    // A new result never overwrites one that is still waiting.
    `FTIG_ASSERT_NOW(a_no_overwrite, aclk, aresetn, cmd.emit, !m_tvalid || m_tready, "result overwritten")
    // While a request can be taken, the datapath is not working on a frame.
    `FTIG_ASSERT_NOW(a_idle_quiet, aclk, aresetn, s_tready, !(cmd.mul_en || cmd.div_step || cmd.add_gap || cmd.add_frame), "datapath busy while ready")
    // An accepted request keeps the input closed in the next cycle.
    `FTIG_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready, !s_tready, "ready right after accept")

endmodule

// File: hw/rtl/ftig_ctrl.sv
module ftig_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  ftig_pkg::ctrl_status_t status,
    output ftig_pkg::ctrl_cmd_t    cmd
);
    import ftig_pkg::*;

    typedef enum logic [9:0] {
        ST_IDLE = 10'b00_0000_0001,
        ST_DUR  = 10'b00_0000_0010,
        ST_ADD1 = 10'b00_0000_0100,
        ST_PROD = 10'b00_0000_1000,
        ST_CHK  = 10'b00_0001_0000,
        ST_DIV  = 10'b00_0010_0000,
        ST_Y    = 10'b00_0100_0000,
        ST_GMUL = 10'b00_1000_0000,
        ST_ADD2 = 10'b01_0000_0000,
        ST_FIN  = 10'b10_0000_0000
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    // Sequencer: one frame at a time, gap path only when a gap exists.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.mul_sel = MUL_DUR;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid) begin
                    state_next = ST_DUR;
                end
            end
            ST_DUR: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_DUR;
                state_next  = ST_ADD1;
            end
            ST_ADD1: begin
                cmd.add_frame = 1'b1;
                state_next    = status.gap_needed ? ST_PROD : ST_FIN;
            end
            ST_PROD: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_INTERP;
                state_next  = ST_CHK;
            end
            ST_CHK: begin
                cmd.div_init = 1'b1;
                cnt_next     = DIV_CNT_W'(DIV_STEPS - 1);
                state_next   = status.big ? ST_Y : ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = ST_Y;
                end
            end
            ST_Y: begin
                cmd.interp_en = 1'b1;
                state_next    = ST_GMUL;
            end
            ST_GMUL: begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_GAP;
                state_next  = ST_ADD2;
            end
            ST_ADD2: begin
                cmd.add_gap = 1'b1;
                state_next  = ST_FIN;
            end
            ST_FIN: begin
                // A last frame waits until the output register is free.
                if (!status.is_last || !status.out_busy) begin
                    cmd.finish = 1'b1;
                    cmd.emit   = status.is_last;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hw/rtl/ftig_dp.sv
module ftig_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                times_present,
    input  logic [ftig_pkg::S_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tuser,
    input  logic                                s_tlast,
    input  ftig_pkg::ctrl_cmd_t                  cmd,
    output ftig_pkg::ctrl_status_t               status,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [ftig_pkg::ACC_W-1:0]          m_tdata,
    output logic [1:0]                          m_tuser
);
    import ftig_pkg::*;

    // Captured frame.
    logic signed [VALUE_W-1:0] value_reg;
    logic [TIME_W-1:0]         start_reg, end_reg, mid_reg;
    logic                      first_reg, last_reg;

    // Previous frame and run state.
    logic signed [VALUE_W-1:0] prev_value_reg;
    logic [TIME_W-1:0]         prev_end_reg, prev_mid_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic                      err_reg, ovf_reg;

    // Working registers.
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic [DEN_W-1:0]          rem_reg;
    logic [QCLAMP_BITS-1:0]    low_reg;
    logic [QUOT_W-1:0]         quot_reg;
    logic signed [VALUE_W-1:0] y_reg;

    // Output register.
    logic                      out_valid_reg;
    logic [ACC_W-1:0]          out_data_reg;
    logic [1:0]                out_user_reg;

    // Returns the overflow flag above the saturated 64-bit sum.
    function automatic logic [ACC_W:0] sat_add(input logic signed [ACC_W-1:0] a,
                                               input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        logic [ACC_W:0]        r;
        s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (s[ACC_W] != s[ACC_W-1]) begin
            r = {1'b1, s[ACC_W], {(ACC_W-1){~s[ACC_W]}}};
        end else begin
            r = {1'b0, s[ACC_W-1:0]};
        end
        return r;
    endfunction

    // Frame timing terms.
    logic [TIME_W:0]     dur_w, gap_w;
    logic                dur_neg, gap_pos, mid_up;
    logic signed [VALUE_W:0]   dv;
    logic signed [TIME_W+2:0]  num;
    logic [VALUE_W:0]    dv_mag;
    logic [TIME_W+2:0]   num_mag;
    logic [DEN_W-1:0]    den;

    assign dur_w   = {1'b0, end_reg} - {1'b0, start_reg};
    assign dur_neg = dur_w[TIME_W];
    assign gap_w   = {1'b0, start_reg} - {1'b0, prev_end_reg};
    assign gap_pos = !gap_w[TIME_W] && (gap_w != '0);
    assign mid_up  = mid_reg > prev_mid_reg;
    assign dv      = {value_reg[VALUE_W-1], value_reg}
                   - {prev_value_reg[VALUE_W-1], prev_value_reg};
    assign num     = $signed({3'b000, start_reg}) + $signed({3'b000, prev_end_reg})
                   - $signed({2'b00, prev_mid_reg, 1'b0});
    assign dv_mag  = dv[VALUE_W] ? ((VALUE_W+1)'(0) - dv) : dv;
    assign num_mag = num[TIME_W+2] ? ((TIME_W+3)'(0) - num) : num;
    assign den     = {mid_reg - prev_mid_reg, 1'b0};

    // Shared multiplier operands.
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [PROD_W-1:0] mul_p;

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_DUR: begin
                mul_a = {{(MUL_W-VALUE_W){value_reg[VALUE_W-1]}}, value_reg};
                mul_b = times_present ? {{(MUL_W-TIME_W){1'b0}}, dur_w[TIME_W-1:0]}
                                      : UNIT_DURATION;
            end
            MUL_INTERP: begin
                mul_a = {1'b0, dv_mag};
                mul_b = {1'b0, num_mag[DEN_W-1:0]};
            end
            MUL_GAP: begin
                mul_a = {{(MUL_W-TIME_W){1'b0}}, gap_w[TIME_W-1:0]};
                mul_b = {{(MUL_W-VALUE_W){y_reg[VALUE_W-1]}}, y_reg};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider setup and step.
    logic [DIVD_W-1:0]             divd;
    logic [DIVD_W+QCLAMP_BITS-1:0] den_sh;
    logic                          big;
    logic [DEN_W:0]                trial;
    logic                          ge;

    assign divd   = prod_reg[DIVD_W-1:0];
    assign den_sh = {{(DIVD_W-DEN_W){1'b0}}, den, {QCLAMP_BITS{1'b0}}};
    assign big    = {{QCLAMP_BITS{1'b0}}, divd} >= den_sh;
    assign trial  = {rem_reg, low_reg[QCLAMP_BITS-1]};
    assign ge     = trial >= {1'b0, den};

    // Interpolated value, saturated to the value range.
    logic signed [QUOT_W:0]    yw;
    logic signed [VALUE_W-1:0] y_sat;

    always_comb begin
        if (neg_reg) begin
            yw = {{(QUOT_W+1-VALUE_W){prev_value_reg[VALUE_W-1]}}, prev_value_reg}
               - $signed({1'b0, quot_reg});
        end else begin
            yw = {{(QUOT_W+1-VALUE_W){prev_value_reg[VALUE_W-1]}}, prev_value_reg}
               + $signed({1'b0, quot_reg});
        end
        if (yw[QUOT_W:VALUE_W-1] == '0 || yw[QUOT_W:VALUE_W-1] == '1) begin
            y_sat = yw[VALUE_W-1:0];
        end else begin
            y_sat = {yw[QUOT_W], {(VALUE_W-1){~yw[QUOT_W]}}};
        end
    end

    // Accumulator updates.
    logic [ACC_W:0] add_res;
    assign add_res = sat_add(acc_reg, prod_reg[ACC_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_value_reg <= '0;
            prev_end_reg   <= '0;
            prev_mid_reg   <= '0;
            acc_reg        <= '0;
            err_reg        <= 1'b0;
            ovf_reg        <= 1'b0;
        end else begin
            if (cmd.capture && s_tuser) begin
                acc_reg <= '0;
                err_reg <= 1'b0;
                ovf_reg <= 1'b0;
            end
            if (cmd.add_frame) begin
                // With times, a negative duration or a non-rising mid flags the run.
                if (times_present && (dur_neg || (!first_reg && !mid_up))) begin
                    err_reg <= 1'b1;
                end
                if (!(times_present && dur_neg)) begin
                    acc_reg <= add_res[ACC_W-1:0];
                    if (add_res[ACC_W]) begin
                        ovf_reg <= 1'b1;
                    end
                end
            end
            if (cmd.add_gap) begin
                acc_reg <= add_res[ACC_W-1:0];
                if (add_res[ACC_W]) begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.finish) begin
                prev_value_reg <= value_reg;
                prev_end_reg   <= end_reg;
                prev_mid_reg   <= mid_reg;
            end
        end
    end

    // Frame capture, multiplier, divider and interpolation registers.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            value_reg <= s_tdata[VALUE_W-1:0];
            start_reg <= s_tdata[VALUE_W +: TIME_W];
            end_reg   <= s_tdata[VALUE_W+TIME_W +: TIME_W];
            mid_reg   <= s_tdata[VALUE_W+2*TIME_W +: TIME_W];
            first_reg <= s_tuser;
            last_reg  <= s_tlast;
        end
        if (cmd.mul_en) begin
            prod_reg <= mul_p;
        end
        if (cmd.mul_en && cmd.mul_sel == MUL_INTERP) begin
            neg_reg <= dv[VALUE_W] ^ num[TIME_W+2];
        end
        if (cmd.div_init) begin
            rem_reg  <= {{(DEN_W-(DIVD_W-QCLAMP_BITS)){1'b0}}, divd[DIVD_W-1:QCLAMP_BITS]};
            low_reg  <= divd[QCLAMP_BITS-1:0];
            quot_reg <= big ? (QUOT_W'(1) << QCLAMP_BITS) : '0;
        end
        if (cmd.div_step) begin
            rem_reg  <= ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
            low_reg  <= {low_reg[QCLAMP_BITS-2:0], 1'b0};
            quot_reg <= {quot_reg[QUOT_W-2:0], ge};
        end
        if (cmd.interp_en) begin
            y_reg <= y_sat;
        end
    end

    // Result register: loaded on a last frame, held until taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            out_data_reg <= acc_reg;
            out_user_reg <= {ovf_reg, err_reg};
        end
    end

    assign status.gap_needed = times_present && !first_reg && mid_up && gap_pos;
    assign status.big        = big;
    assign status.is_last    = last_reg;
    assign status.out_busy   = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule
